FILE: sv/masq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masq_pkg
// Shared codes, reset values and divider handshake types for the masked
// Q-learning table.
// ----------------------------------------------------------------------------
package masq_pkg;

  localparam int BK_ROWS = 162;

  // request codes
  localparam logic [1:0] REQ_SELECT = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LEARN_RATE     = 3'd0;
  localparam cfg_idx_t CFG_DISCOUNT       = 3'd1;
  localparam cfg_idx_t CFG_EXPLORE_START  = 3'd2;
  localparam cfg_idx_t CFG_EXPLORE_FLOOR  = 3'd3;
  localparam cfg_idx_t CFG_DECAY_EPISODES = 3'd4;
  localparam cfg_idx_t CFG_EVAL_ONLY      = 3'd5;

  localparam logic [15:0] LEARN_RATE_RST    = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST      = 16'd58982;
  localparam logic [15:0] EXPLORE_START_RST = 16'd65535;
  localparam logic [15:0] EXPLORE_FLOOR_RST = 16'd3277;
  localparam logic [15:0] DECAY_RST         = 16'd1000;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

FILE: sv/masq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masq_in_if
// Request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface masq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         bkt0;
  logic [1:0]         bkt1;
  logic [1:0]         bkt2;
  logic               bkt3;
  logic [1:0]         bkt4;
  logic [4:0]         done_mask;
  logic [4:0]         next_done_mask;
  logic [2:0]         taken_action;
  logic signed [31:0] reward;
  logic [15:0]        explore_draw;
  logic [15:0]        pick_draw;

  modport source (output valid, req_type, bkt0, bkt1, bkt2,
                  bkt3, bkt4, done_mask, next_done_mask, taken_action,
                  reward, explore_draw, pick_draw, input ready);
  modport sink (input valid, req_type, bkt0, bkt1, bkt2,
                bkt3, bkt4, done_mask, next_done_mask, taken_action,
                reward, explore_draw, pick_draw, output ready);
endinterface

FILE: sv/masq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masq_out_if
// Result channel: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface masq_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         chosen_action;
  logic               explored;
  logic signed [31:0] q_value;
  logic [15:0]        episode_count;

  modport source (output valid, chosen_action, explored, q_value, episode_count,
                  input ready);
  modport sink (input valid, chosen_action, explored, q_value, episode_count,
                output ready);
endinterface

FILE: sv/masq_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface masq_cfg_if;
  import masq_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/masked_q_learning_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_q_learning_table
// Tabular Q-learning engine with epsilon-greedy choice over masked actions.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_ch (valid/ready), one result beat leaves on
// out_ch for every request. cfg_ch writes the six registers and is always
// ready; write it only while no request is in flight.
// One request is worked on at a time; in_ch.ready is high only when idle.
// Work per request, set by the single table read port and the divider:
//   end episode / no-op: no table access
//   update: walk of the next-state row, one entry a cycle
//   select: walk of the row, plus a divide while epsilon still decays,
//   plus another divide when exploring (pick draw mod available count)
// The divider resolves one quotient bit a cycle and is shared by both uses.
// After reset the table is swept to zero, one entry a cycle, over all
// 162*MASK_STATES*ACTION_CNT entries (31104 at defaults); no request is
// taken meanwhile. A finished result sits in an output register; a stalled
// receiver holds it and blocks only the end of the next request.
// ----------------------------------------------------------------------------
module masked_q_learning_table #(
  parameter int ACTION_CNT  = 6,
  parameter int MASK_STATES = 32,
  parameter int Q_WIDTH     = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  masq_in_if.sink    in_ch,
  masq_out_if.source out_ch,
  masq_cfg_if.sink   cfg_ch
);
  import masq_pkg::*;

  localparam int DEPTH  = BK_ROWS * MASK_STATES * ACTION_CNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AW     = $clog2(ACTION_CNT);
  localparam int NW     = $clog2(ACTION_CNT + 1);
  localparam int MM_W   = $clog2(MASK_STATES);
  localparam int MW     = ((Q_WIDTH > 32) ? Q_WIDTH : 32) + 2;
  localparam int PW     = MW + 17;
  localparam logic [AW-1:0] STOP_A = AW'(ACTION_CNT - 1);
  localparam logic signed [MW:0] Q_MAX = (MW+1)'((65'sd1 <<< (Q_WIDTH - 1)) - 65'sd1);
  localparam logic signed [MW:0] Q_MIN = -Q_MAX - (MW+1)'(1);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_ADDR  = 15'b000000000000100,
    S_EDIV  = 15'b000000000001000,
    S_EXPL  = 15'b000000000010000,
    S_PDIV  = 15'b000000000100000,
    S_SCAN  = 15'b000000001000000,
    S_LAST  = 15'b000000010000000,
    S_CUR   = 15'b000000100000000,
    S_CURW  = 15'b000001000000000,
    S_MUL1  = 15'b000010000000000,
    S_ADD1  = 15'b000100000000000,
    S_MUL2  = 15'b001000000000000,
    S_ADD2  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  // configuration
  logic [15:0] alpha_r, gamma_r, eps_start_r, eps_floor_r, decay_r;
  logic        eval_only_r;

  // sequencer and request state
  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_r, clr_nxt;
  logic [15:0]              ep_r, ep_nxt;
  logic [1:0]               req_r;
  logic [7:0]               bk_r;
  logic [4:0]               mask_r, nmask_r;
  logic [2:0]               ta_r;
  logic signed [31:0]       rew_r;
  logic [15:0]              edraw_r, pdraw_r;
  logic [ADDR_W-1:0]        base_r, base_nxt, nbase_r, nbase_nxt;
  logic [15:0]              eps_r, eps_nxt;
  logic                     expl_r, expl_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW-1:0]            a_r, a_nxt;
  logic                     rd_v_r, rd_v_nxt;
  logic [AW-1:0]            rd_a_r, rd_a_nxt;
  logic                     found_r, found_nxt;
  logic [AW-1:0]            best_a_r, best_a_nxt;
  logic signed [Q_WIDTH-1:0] best_q_r, best_q_nxt;
  logic signed [Q_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [Q_WIDTH-1:0] res_q_r, res_q_nxt;
  logic signed [MW-1:0]     target_r, target_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;

  // output register
  logic                     out_v_r, out_v_nxt;
  logic [2:0]               out_a_r, out_a_nxt;
  logic                     out_e_r, out_e_nxt;
  logic signed [31:0]       out_q_r, out_q_nxt;
  logic [15:0]              out_ep_r, out_ep_nxt;

  // table memory
  logic signed [Q_WIDTH-1:0] q_mem [DEPTH];
  logic signed [Q_WIDTH-1:0] mem_q_r;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_wa, mem_ra;
  logic signed [Q_WIDTH-1:0] mem_wd;

  // shared multiplier and divider
  logic signed [MW-1:0] mul_a;
  logic signed [16:0]   mul_b;
  logic signed [PW-1:0] mul_p;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic [MM_W-1:0]   mask_mod [32];
  logic [7:0]        bk_in;
  logic [NW-1:0]     n_avail;
  logic [4:0]        scan_mask;
  logic              scan_expl;
  logic [15:0]       eps_span;
  logic              start_ge;
  logic [15:0]       quo16;
  logic signed [MW:0] nq;
  logic signed [Q_WIDTH-1:0] nq_sat;
  logic signed [MW-1:0] out_q_ext;

  function automatic logic avail(input logic [4:0] m, input logic [AW-1:0] a);
    if (int'(a) >= ACTION_CNT - 1 || int'(a) >= 5) return 1'b1;
    return !m[3'(a)];
  endfunction

  function automatic logic [1:0] sat3(input logic [1:0] v);
    return (v == 2'd3) ? 2'd2 : v;
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(input logic [7:0] bk,
                                                  input logic [MM_W-1:0] mm);
    return (ADDR_W'(bk) * ADDR_W'(MASK_STATES) + ADDR_W'(mm)) * ADDR_W'(ACTION_CNT);
  endfunction

  for (genvar i = 0; i < 32; i++) begin : g_mod
    assign mask_mod[i] = MM_W'(i % MASK_STATES);
  end

  assign bk_in = ((((8'(sat3(in_ch.bkt0)) * 8'd3 + 8'(sat3(in_ch.bkt1)))
                  * 8'd3 + 8'(sat3(in_ch.bkt2))) * 8'd2 + 8'(in_ch.bkt3))
                  * 8'd3 + 8'(sat3(in_ch.bkt4)));

  always_comb begin
    n_avail = '0;
    for (int a = 0; a < ACTION_CNT; a++) begin
      n_avail = n_avail + NW'(avail(mask_r, AW'(a)));
    end
  end

  masq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign start_ge  = eps_start_r >= eps_floor_r;
  assign eps_span  = start_ge ? eps_start_r - eps_floor_r : eps_floor_r - eps_start_r;
  assign quo16     = div_rsp.quotient[15:0];
  assign scan_mask = (req_r == REQ_SELECT) ? mask_r : nmask_r;
  assign scan_expl = (req_r == REQ_SELECT) && expl_r;

  always_comb begin
    unique case (state_r)
      S_MUL1: begin
        mul_a = MW'(best_q_r);
        mul_b = {1'b0, gamma_r};
      end
      S_MUL2: begin
        mul_a = target_r - MW'(cur_r);
        mul_b = {1'b0, alpha_r};
      end
      default: begin
        mul_a = MW'(signed'({1'b0, eps_span}));
        mul_b = {1'b0, ep_r};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign nq     = (MW+1)'(cur_r) + (MW+1)'(prod_r >>> 16);
  assign nq_sat = (nq > Q_MAX) ? Q_WIDTH'(Q_MAX) :
                  (nq < Q_MIN) ? Q_WIDTH'(Q_MIN) : Q_WIDTH'(nq);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    ep_nxt     = ep_r;
    base_nxt   = base_r;
    nbase_nxt  = nbase_r;
    eps_nxt    = eps_r;
    expl_nxt   = expl_r;
    k_nxt      = k_r;
    a_nxt      = a_r;
    rd_v_nxt   = 1'b0;
    rd_a_nxt   = rd_a_r;
    found_nxt  = found_r;
    best_a_nxt = best_a_r;
    best_q_nxt = best_q_r;
    cur_nxt    = cur_r;
    res_q_nxt  = res_q_r;
    target_nxt = target_r;
    prod_nxt   = prod_r;
    out_v_nxt  = out_v_r;
    out_a_nxt  = out_a_r;
    out_e_nxt  = out_e_r;
    out_q_nxt  = out_q_r;
    out_ep_nxt = out_ep_r;
    out_q_ext  = MW'(best_q_r);
    mem_we     = 1'b0;
    mem_wa     = clr_r;
    mem_wd     = '0;
    mem_ra     = ((req_r == REQ_SELECT) ? base_r : nbase_r) + ADDR_W'(a_r);
    div_req    = '0;

    if (out_v_r && out_ch.ready) out_v_nxt = 1'b0;

    // fold in the entry read last cycle
    if (rd_v_r && avail(scan_mask, rd_a_r)) begin
      if (scan_expl) begin
        if (!found_r) begin
          if (k_r == '0) begin
            found_nxt  = 1'b1;
            best_a_nxt = rd_a_r;
            best_q_nxt = mem_q_r;
          end else begin
            k_nxt = k_r - AW'(1);
          end
        end
      end else if (!found_r || mem_q_r > best_q_r) begin
        found_nxt  = 1'b1;
        best_a_nxt = rd_a_r;
        best_q_nxt = mem_q_r;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        base_nxt   = row_base(bk_r, mask_mod[mask_r]);
        nbase_nxt  = row_base(bk_r, mask_mod[nmask_r]);
        found_nxt  = 1'b0;
        best_a_nxt = STOP_A;
        best_q_nxt = '0;
        a_nxt      = '0;
        res_q_nxt  = '0;
        expl_nxt   = 1'b0;
        if (req_r == REQ_SELECT) begin
          if (ep_r < decay_r) begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_p[31:0];
            div_req.divisor  = decay_r;
            state_nxt        = S_EDIV;
          end else begin
            eps_nxt   = eps_floor_r;
            state_nxt = S_EXPL;
          end
        end else if (req_r == REQ_UPDATE) begin
          state_nxt = (int'(ta_r) < ACTION_CNT) ? S_SCAN : S_DONE;
        end else begin
          if (req_r == REQ_END && !eval_only_r && ep_r != 16'hFFFF)
            ep_nxt = ep_r + 16'd1;
          state_nxt = S_DONE;
        end
      end
      S_EDIV: begin
        if (div_rsp.done) begin
          eps_nxt   = start_ge ? eps_start_r - quo16 : eps_start_r + quo16;
          state_nxt = S_EXPL;
        end
      end
      S_EXPL: begin
        if (edraw_r < eps_r) begin
          expl_nxt         = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = {16'd0, pdraw_r};
          div_req.divisor  = 16'(n_avail);
          state_nxt        = S_PDIV;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          k_nxt     = AW'(div_rsp.remainder);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_v_nxt = 1'b1;
        rd_a_nxt = a_r;
        if (a_r == STOP_A) state_nxt = S_LAST;
        else a_nxt = a_r + AW'(1);
      end
      S_LAST: begin
        state_nxt = (req_r == REQ_SELECT) ? S_DONE : S_CUR;
      end
      S_CUR: begin
        mem_ra    = base_r + ADDR_W'(ta_r);
        state_nxt = S_CURW;
      end
      S_CURW: begin
        cur_nxt   = mem_q_r;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        target_nxt = MW'(rew_r) + MW'(prod_r >>> 16);
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        mem_we    = 1'b1;
        mem_wa    = base_r + ADDR_W'(ta_r);
        mem_wd    = nq_sat;
        res_q_nxt = nq_sat;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt  = 1'b1;
          out_ep_nxt = ep_r;
          if (req_r == REQ_SELECT) begin
            out_a_nxt = 3'(best_a_r);
            out_e_nxt = expl_r;
            out_q_ext = MW'(best_q_r);
          end else begin
            out_a_nxt = '0;
            out_e_nxt = 1'b0;
            out_q_ext = MW'(res_q_r);
          end
          out_q_nxt = out_q_ext[31:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) q_mem[mem_wa] <= mem_wd;
    mem_q_r <= q_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ep_r        <= '0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      alpha_r     <= LEARN_RATE_RST;
      gamma_r     <= DISCOUNT_RST;
      eps_start_r <= EXPLORE_START_RST;
      eps_floor_r <= EXPLORE_FLOOR_RST;
      decay_r     <= DECAY_RST;
      eval_only_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ep_r    <= ep_nxt;
      rd_v_r  <= rd_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_LEARN_RATE:     alpha_r     <= cfg_ch.data;
          CFG_DISCOUNT:       gamma_r     <= cfg_ch.data;
          CFG_EXPLORE_START:  eps_start_r <= cfg_ch.data;
          CFG_EXPLORE_FLOOR:  eps_floor_r <= cfg_ch.data;
          CFG_DECAY_EPISODES: decay_r     <= cfg_ch.data;
          CFG_EVAL_ONLY:      eval_only_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
    if (state_r == S_IDLE && in_ch.valid) begin
      req_r   <= in_ch.req_type;
      bk_r    <= bk_in;
      mask_r  <= in_ch.done_mask;
      nmask_r <= in_ch.next_done_mask;
      ta_r    <= in_ch.taken_action;
      rew_r   <= in_ch.reward;
      edraw_r <= in_ch.explore_draw;
      pdraw_r <= in_ch.pick_draw;
    end
    base_r   <= base_nxt;
    nbase_r  <= nbase_nxt;
    eps_r    <= eps_nxt;
    expl_r   <= expl_nxt;
    k_r      <= k_nxt;
    a_r      <= a_nxt;
    rd_a_r   <= rd_a_nxt;
    found_r  <= found_nxt;
    best_a_r <= best_a_nxt;
    best_q_r <= best_q_nxt;
    cur_r    <= cur_nxt;
    res_q_r  <= res_q_nxt;
    target_r <= target_nxt;
    prod_r   <= prod_nxt;
    out_a_r  <= out_a_nxt;
    out_e_r  <= out_e_nxt;
    out_q_r  <= out_q_nxt;
    out_ep_r <= out_ep_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_v_r;
  assign out_ch.chosen_action = out_a_r;
  assign out_ch.explored      = out_e_r;
  assign out_ch.q_value       = out_q_r;
  assign out_ch.episode_count = out_ep_r;

endmodule

FILE: sv/masq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masq_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a
// cycle. Done pulses for one cycle after the last step.
// ----------------------------------------------------------------------------
module masq_div (
  input  logic                clk,
  input  logic                rst_n,
  input  masq_pkg::div_req_t  req,
  output masq_pkg::div_rsp_t  rsp
);
  import masq_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [15:0] den_r, den_nxt;
  logic [16:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    shifted  = {rem_r, quo_r[31]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = 16'(shifted - {1'b0, den_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: sv/masq_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masq_check
// Port-level checks for the masked Q-learning table, bound to the top level.
// ----------------------------------------------------------------------------
module masq_check #(
  parameter int ACTION_CNT = 6
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_chosen_action,
  input logic [31:0] out_q_value
);

  // one request at a time: no beat straight after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // table sweep after reset blocks requests
  a_reset_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready straight after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_q_value))
    else $error("stalled result dropped or changed");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_chosen_action) < ACTION_CNT)
    else $error("chosen action out of range");

endmodule

bind masked_q_learning_table masq_check #(.ACTION_CNT(ACTION_CNT)) u_masq_check (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_chosen_action (out_ch.chosen_action),
  .out_q_value       (out_ch.q_value)
);
